/* hdl/chirp_dechirp_mixer_assert.svh */
// Assertion macros for the chirp dechirp mixer.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in the using module.
`ifndef CHIRP_DECHIRP_MIXER_ASSERT_SVH
`define CHIRP_DECHIRP_MIXER_ASSERT_SVH

`ifndef SYNTH
`define CDM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("chirp_dechirp_mixer assertion failed");
`define CDM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("chirp_dechirp_mixer assertion failed");
`else
`define CDM_ASSERT_IMPL(label, ante, cons)
`define CDM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* hdl/cdm_pkg.sv */
// Shared types and constants for the chirp dechirp mixer.
// No dependencies.
package cdm_pkg;

    localparam int Q15_W     = 15;
    localparam int FRAC_BITS = 15;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 4;
    localparam int REC_W     = 21;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int          REC_LEN_RST = 1024;

    typedef enum logic [1:0] {
        REG_START_INC = 2'd0,
        REG_CHIRP     = 2'd1,
        REG_LFM_EN    = 2'd2,
        REG_REC_LEN   = 2'd3
    } t_reg_idx;

endpackage

/* hdl/chirp_dechirp_mixer.sv */
// Throughput: one transaction per cycle while o_stall is low. An accepted transaction passes the
// sine RAM read, the multiply stage and the output add, each one stage, before its result is on
// the output register. After reset the quarter-wave sine RAM is loaded with
// 2^(TABLE_ADDR_BITS-2)+1 entries (1025 by default), one entry a cycle, while o_stall is high;
// configuration writes are taken during the load. Depends on cdm_pkg, cdm_ram and the macro header.
`include "chirp_dechirp_mixer_assert.svh"

module chirp_dechirp_mixer
    import cdm_pkg::*;
#(
    parameter int SAMPLE_WIDTH    = 16,
    parameter int PHASE_WIDTH     = 32,
    parameter int TABLE_ADDR_BITS = 12,
    parameter int MAX_RECORD_LEN  = 1048576
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_in_re,
    input  logic signed [SAMPLE_WIDTH-1:0] i_in_im,
    input  logic                           i_in_last,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [SAMPLE_WIDTH:0]   o_out_re,
    output logic signed [SAMPLE_WIDTH:0]   o_out_im,
    output logic                           o_out_last,
    output logic                           o_length_error,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [APB_AW-1:0]              paddr,
    input  logic [APB_DW-1:0]              pwdata,
    output logic [APB_DW-1:0]              prdata,
    output logic                           pready
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int PW     = PHASE_WIDTH;
    localparam int TAB    = TABLE_ADDR_BITS;
    localparam int QB     = TABLE_ADDR_BITS - 2;
    localparam int QDEPTH = (1 << QB) + 1;
    localparam int QAW    = QB + 1;
    localparam int IDX_W  = $clog2(MAX_RECORD_LEN);
    localparam int LW     = ($clog2(MAX_RECORD_LEN + 1) > REC_W) ?
                            $clog2(MAX_RECORD_LEN + 1) : REC_W;
    localparam int PROD_W = SW + Q15_W + 1;
    localparam int SUM_W  = PROD_W + 1;

    localparam logic [QAW-1:0]   QUARTER    = QAW'(1) << QB;
    localparam logic [QAW-1:0]   FILL_LAST  = QAW'(QDEPTH - 1);
    localparam logic [IDX_W-1:0] LEN_M1_RST =
        IDX_W'(((REC_LEN_RST > MAX_RECORD_LEN) ? MAX_RECORD_LEN : REC_LEN_RST) - 1);

    function automatic logic [QDEPTH*Q15_W-1:0] qtab_build();
        logic [QDEPTH*Q15_W-1:0] tab;
        longint unsigned         x;
        longint unsigned         x2;
        longint unsigned         term;
        longint                  sum;
        tab = '0;
        for (int m = 0; m < QDEPTH; m++) begin
            x    = (HALF_PI_Q30 * 64'(m)) >> QB;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            term = ((term * x2) >> 30) / 6;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 20;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 42;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 72;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 110;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 156;
            sum  = sum + longint'(term);
            if (sum < 0) begin
                sum = 0;
            end
            sum = (sum + 16384) >>> 15;
            if (sum > 32767) begin
                sum = 32767;
            end
            tab[m*Q15_W +: Q15_W] = Q15_W'(sum);
        end
        return tab;
    endfunction

    localparam logic [QDEPTH*Q15_W-1:0] QTAB = qtab_build();

    // configuration
    logic [31:0]      r_start;
    logic [31:0]      r_chirp;
    logic             r_lfm_en;
    logic [REC_W-1:0] r_rec_len;
    logic [IDX_W-1:0] r_len_m1;

    logic             w_cfg_wr;
    t_reg_idx         w_cfg_idx;
    logic [LW-1:0]    w_len_ext;
    logic [LW-1:0]    w_len_clamp;

    // accumulators
    logic [PW-1:0]    r_phase;
    logic [PW-1:0]    r_freq;
    logic [IDX_W-1:0] r_sample_idx;

    // table load
    logic             r_filling;
    logic [QAW-1:0]   r_fill_addr;

    // pipeline
    logic                 r_v1, r_v2, r_v3;
    logic                 w_en1, w_en2, w_en3;
    logic                 w_acc;
    logic signed [SW-1:0] r_re1, r_im1;
    logic                 r_last1, r_err1, r_negs1, r_negc1;
    logic [Q15_W-1:0]     w_sq, w_cq;
    logic signed [PROD_W-1:0] r_pac, r_pbs, r_pbc, r_pas;
    logic                 r_last2, r_err2;
    logic signed [SW:0]   r_out_re, r_out_im;
    logic                 r_last3, r_err3;

    logic [TAB-1:0]       w_addr;
    logic [1:0]           w_quad_s, w_quad_c;
    logic [QAW-1:0]       w_r_ext;
    logic [QAW-1:0]       w_m_s, w_m_c;
    logic                 w_last_out, w_err, w_restart;
    logic signed [Q15_W:0] w_s, w_c;
    logic signed [SUM_W-1:0] w_sum_re, w_sum_im;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = t_reg_idx'(paddr[3:2]);

    assign w_len_ext   = LW'(pwdata[REC_W-1:0]);
    assign w_len_clamp = (w_len_ext == '0) ? LW'(1) :
                         (w_len_ext > LW'(MAX_RECORD_LEN)) ? LW'(MAX_RECORD_LEN) : w_len_ext;

    always_comb begin
        unique case (w_cfg_idx)
            REG_START_INC: prdata = r_start;
            REG_CHIRP:     prdata = r_chirp;
            REG_LFM_EN:    prdata = APB_DW'(r_lfm_en);
            REG_REC_LEN:   prdata = APB_DW'(r_rec_len);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start   <= '0;
            r_chirp   <= '0;
            r_lfm_en  <= 1'b1;
            r_rec_len <= REC_W'(REC_LEN_RST);
            r_len_m1  <= LEN_M1_RST;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                REG_START_INC: r_start   <= pwdata;
                REG_CHIRP:     r_chirp   <= pwdata;
                REG_LFM_EN:    r_lfm_en  <= pwdata[0];
                REG_REC_LEN: begin
                    r_rec_len <= pwdata[REC_W-1:0];
                    r_len_m1  <= IDX_W'(w_len_clamp - LW'(1));
                end
                default: ;
            endcase
        end
    end

    // handshake
    assign w_en3   = !r_v3 || !i_stall;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_stall = r_filling || !w_en1;
    assign w_acc   = i_valid && !o_stall;

    // reference address
    assign w_addr   = r_phase[PW-1 -: TAB];
    assign w_quad_s = w_addr[TAB-1:TAB-2];
    assign w_quad_c = w_quad_s + 2'd1;
    assign w_r_ext  = {1'b0, w_addr[QB-1:0]};
    assign w_m_s    = w_quad_s[0] ? QUARTER - w_r_ext : w_r_ext;
    assign w_m_c    = w_quad_c[0] ? QUARTER - w_r_ext : w_r_ext;

    assign w_last_out = (r_sample_idx == r_len_m1);
    assign w_err      = w_last_out != i_in_last;
    assign w_restart  = w_last_out || i_in_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= '0;
            r_freq       <= '0;
            r_sample_idx <= '0;
        end else if (w_cfg_wr) begin
            r_phase      <= '0;
            r_freq       <= PW'((w_cfg_idx == REG_START_INC) ? pwdata : r_start);
            r_sample_idx <= '0;
        end else if (w_acc) begin
            if (w_restart) begin
                r_phase      <= '0;
                r_freq       <= PW'(r_start);
                r_sample_idx <= '0;
            end else begin
                r_phase <= r_phase + r_freq;
                if (r_lfm_en) begin
                    r_freq <= r_freq + PW'(signed'(r_chirp));
                end
                r_sample_idx <= r_sample_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filling   <= 1'b1;
            r_fill_addr <= '0;
        end else if (r_filling) begin
            r_fill_addr <= r_fill_addr + QAW'(1);
            if (r_fill_addr == FILL_LAST) begin
                r_filling <= 1'b0;
            end
        end
    end

    cdm_ram #(
        .WIDTH (Q15_W),
        .DEPTH (QDEPTH)
    ) u_sin_ram (
        .i_clk     (i_clk),
        .i_we      (r_filling),
        .i_waddr   (r_fill_addr),
        .i_wdata   (QTAB[r_fill_addr*Q15_W +: Q15_W]),
        .i_re      (w_en1),
        .i_raddr_a (w_m_s),
        .i_raddr_b (w_m_c),
        .o_rdata_a (w_sq),
        .o_rdata_b (w_cq)
    );

    // stage 1: sample and table data
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_re1   <= i_in_re;
            r_im1   <= i_in_im;
            r_last1 <= w_last_out;
            r_err1  <= w_err;
            r_negs1 <= w_quad_s[1];
            r_negc1 <= w_quad_c[1];
        end
    end

    assign w_s = r_negs1 ? -signed'({1'b0, w_sq}) : signed'({1'b0, w_sq});
    assign w_c = r_negc1 ? -signed'({1'b0, w_cq}) : signed'({1'b0, w_cq});

    // stage 2: products
    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_pac   <= r_re1 * w_c;
            r_pbs   <= r_im1 * w_s;
            r_pbc   <= r_im1 * w_c;
            r_pas   <= r_re1 * w_s;
            r_last2 <= r_last1;
            r_err2  <= r_err1;
        end
    end

    assign w_sum_re = SUM_W'(r_pac) + SUM_W'(r_pbs);
    assign w_sum_im = SUM_W'(r_pbc) - SUM_W'(r_pas);

    // stage 3: output register
    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_out_re <= w_sum_re[SW+FRAC_BITS:FRAC_BITS];
            r_out_im <= w_sum_im[SW+FRAC_BITS:FRAC_BITS];
            r_last3  <= r_last2;
            r_err3   <= r_err2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= w_acc;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    assign o_valid        = r_v3;
    assign o_out_re       = r_out_re;
    assign o_out_im       = r_out_im;
    assign o_out_last     = r_last3;
    assign o_length_error = r_err3;

    `CDM_ASSERT_IMPL(a_idx_bound, 1'b1, r_sample_idx <= r_len_m1)
    `CDM_ASSERT_NEXT(a_restart, w_acc && !w_cfg_wr && w_restart,
                     r_sample_idx == '0 && r_phase == '0)
    `CDM_ASSERT_NEXT(a_fill_end, r_filling && r_fill_addr == FILL_LAST, !r_filling && !r_v1)

endmodule

/* hdl/cdm_ram.sv */
// Generic RAM, one write port and two registered read ports.
// No dependencies.
module cdm_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 1025
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* verif/tb_chirp_dechirp_mixer.sv */
// Testbench for chirp_dechirp_mixer: directed and random sample records against a built-in
// dechirp predictor, with APB register setup, random idling and output back-pressure.
// Depends on cdm_pkg and the chirp_dechirp_mixer RTL.
module tb_chirp_dechirp_mixer
    import cdm_pkg::*;
();

    localparam int SW       = 16;
    localparam int TAB_BITS = 12;
    localparam int MAX_LEN  = 1048576;

    typedef struct packed {
        logic signed [SW:0] re;
        logic signed [SW:0] im;
        logic               last;
        logic               err;
    } t_mix_result;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_valid        = 1'b0;
    logic                   o_stall;
    logic signed [SW-1:0]   i_in_re        = '0;
    logic signed [SW-1:0]   i_in_im        = '0;
    logic                   i_in_last      = 1'b0;
    logic                   o_valid;
    logic                   i_stall        = 1'b0;
    logic signed [SW:0]     o_out_re;
    logic signed [SW:0]     o_out_im;
    logic                   o_out_last;
    logic                   o_length_error;
    logic                   psel           = 1'b0;
    logic                   penable        = 1'b0;
    logic                   pwrite         = 1'b0;
    logic [APB_AW-1:0]      paddr          = '0;
    logic [APB_DW-1:0]      pwdata         = '0;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    logic [31:0]            cfg_start_inc  = 32'd0;
    logic [31:0]            cfg_chirp      = 32'd0;
    logic                   cfg_lfm        = 1'b1;
    logic [REC_W-1:0]       cfg_rec_len    = REC_W'(REC_LEN_RST);
    logic [31:0]            phase_acc      = 32'd0;
    logic [31:0]            freq_acc       = 32'd0;
    int unsigned            sample_idx     = 0;

    int                     sine_tab [0:(1<<TAB_BITS)-1];
    t_mix_result            expected_mix_q [$];
    int                     mismatch_count = 0;
    int                     tx_idle_pct    = 0;
    int                     rx_idle_pct    = 0;
    int                     hold_req       = 0;
    int                     hold_left      = 0;

    chirp_dechirp_mixer DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_in_re        (i_in_re),
        .i_in_im        (i_in_im),
        .i_in_last      (i_in_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_re       (o_out_re),
        .o_out_im       (o_out_im),
        .o_out_last     (o_out_last),
        .o_length_error (o_length_error),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #1 i_clk = ~i_clk;

    function automatic longint quarter_wave(input int unsigned m);
        longint unsigned x, x2, term;
        longint          acc;
        x    = (HALF_PI_Q30 * m) >> (TAB_BITS - 2);
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int k = 1; k <= 6; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2) begin
                acc -= longint'(term);
            end else begin
                acc += longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        acc = (acc + 16384) >>> 15;
        if (acc > 32767) begin
            acc = 32767;
        end
        return acc;
    endfunction

    initial begin
        int unsigned qtr, r;
        int          v;
        qtr = 1 << (TAB_BITS - 2);
        for (int a = 0; a < (1 << TAB_BITS); a++) begin
            r = a % qtr;
            v = ((a / qtr) % 2) ? int'(quarter_wave(qtr - r)) : int'(quarter_wave(r));
            sine_tab[a] = ((a / qtr) >= 2) ? -v : v;
        end
    end

    function automatic void log_mismatch(input string msg);
        if (mismatch_count < 10) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
        mismatch_count++;
    endfunction

    task automatic restart_record();
        phase_acc  = 32'd0;
        freq_acc   = cfg_start_inc;
        sample_idx = 0;
    endtask

    task automatic predict_mix(input logic signed [SW-1:0] re, input logic signed [SW-1:0] im,
                               input logic last);
        logic [TAB_BITS-1:0] addr;
        int                  c, s;
        int unsigned         len_eff;
        longint              prod_re, prod_im;
        t_mix_result         res;
        addr    = phase_acc[31 -: TAB_BITS];
        s       = sine_tab[addr];
        c       = sine_tab[TAB_BITS'(addr + (1 << (TAB_BITS - 2)))];
        prod_re = (longint'(re) * c + longint'(im) * s) >>> 15;
        prod_im = (longint'(im) * c - longint'(re) * s) >>> 15;
        len_eff = (cfg_rec_len == 0) ? 1 : ((cfg_rec_len > MAX_LEN) ? MAX_LEN : cfg_rec_len);
        res.re   = prod_re[SW:0];
        res.im   = prod_im[SW:0];
        res.last = (sample_idx == len_eff - 1);
        res.err  = (res.last != last);
        expected_mix_q.push_back(res);
        if (last || res.last) begin
            restart_record();
        end else begin
            phase_acc = phase_acc + freq_acc;
            if (cfg_lfm) begin
                freq_acc = freq_acc + cfg_chirp;
            end
            sample_idx++;
        end
    endtask

    always @(posedge i_clk) begin
        t_mix_result got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_out_re, o_out_im, o_out_last, o_length_error};
            if (expected_mix_q.size() == 0) begin
                log_mismatch($sformatf("unexpected result re=%0d im=%0d last=%0b err=%0b",
                                       got.re, got.im, got.last, got.err));
            end else begin
                want = expected_mix_q.pop_front();
                if (got.re !== want.re || got.im !== want.im ||
                    got.last !== want.last || got.err !== want.err) begin
                    log_mismatch($sformatf(
                        "exp re=%0d im=%0d last=%0b err=%0b, got re=%0d im=%0d last=%0b err=%0b",
                        want.re, want.im, want.last, want.err,
                        got.re, got.im, got.last, got.err));
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    task automatic send_sample(input logic signed [SW-1:0] re, input logic signed [SW-1:0] im,
                               input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_re   <= re;
        i_in_im   <= im;
        i_in_last <= last;
        do @(posedge i_clk); while (o_stall);
        predict_mix(re, im, last);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_mix_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        logic [31:0] rd_exp;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_START_INC: cfg_start_inc = val;
            REG_CHIRP:     cfg_chirp     = val;
            REG_LFM_EN:    cfg_lfm       = val[0];
            REG_REC_LEN:   cfg_rec_len   = val[REC_W-1:0];
        endcase
        restart_record();
        case (idx)
            REG_START_INC: rd_exp = cfg_start_inc;
            REG_CHIRP:     rd_exp = cfg_chirp;
            REG_LFM_EN:    rd_exp = {31'd0, cfg_lfm};
            default:       rd_exp = {{(32 - REC_W){1'b0}}, cfg_rec_len};
        endcase
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== rd_exp) begin
            log_mismatch($sformatf("register %s read exp %h got %h", idx.name(), rd_exp, prdata));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic apply_setting(input logic [31:0] start_inc, input logic [31:0] chirp,
                                 input logic lfm, input logic [31:0] rec_len);
        write_reg(REG_START_INC, start_inc);
        write_reg(REG_CHIRP, chirp);
        write_reg(REG_LFM_EN, {31'd0, lfm});
        write_reg(REG_REC_LEN, rec_len);
    endtask

    task automatic send_records(input int n_items);
        int          sent, kind, rec;
        int unsigned len;
        sent = 0;
        len  = (cfg_rec_len == 0) ? 1 : cfg_rec_len;
        while (sent < n_items) begin
            kind = $urandom_range(99);
            rec  = (kind >= 85) ? $urandom_range(1, len + 3) : len;
            for (int i = 0; i < rec; i++) begin
                send_sample(SW'($urandom()), SW'($urandom()), (i == rec - 1) && (kind < 95));
            end
            sent += rec;
        end
        wait_drained();
    endtask

    task automatic test_directed();
        send_sample(16'sd32767, -16'sd32768, 1'b0);
        send_sample(-16'sd32768, 16'sd32767, 1'b0);
        wait_drained();
        write_reg(REG_REC_LEN, 32'd4);
        write_reg(REG_START_INC, 32'h4000_0000);
        send_sample(16'sd32767, 16'sd32767, 1'b0);
        send_sample(-16'sd32768, -16'sd32768, 1'b0);
        send_sample(-16'sd32768, 16'sd32767, 1'b0);
        send_sample(16'sd32767, -16'sd32768, 1'b1);
        send_sample(16'sd1, -16'sd1, 1'b0);
        send_sample(16'sd0, 16'sd0, 1'b1);
        for (int i = 0; i < 4; i++) begin
            send_sample(16'sd100, -16'sd100, 1'b0);
        end
        send_sample(16'sd5, 16'sd5, 1'b0);
        wait_drained();
        write_reg(REG_CHIRP, 32'h0100_0000);
        for (int i = 0; i < 4; i++) begin
            send_sample(16'sd20000, -16'sd12345, i == 3);
        end
        wait_drained();
        write_reg(REG_REC_LEN, 32'd0);
        send_sample(16'sd7, 16'sd7, 1'b1);
        send_sample(-16'sd7, 16'sd9, 1'b0);
        wait_drained();
        write_reg(REG_REC_LEN, 32'h001F_FFFF);
        send_sample(16'sd3, 16'sd4, 1'b0);
        send_sample(16'sd3, 16'sd4, 1'b1);
        wait_drained();
    endtask

    task automatic test_setting_sweep();
        tx_idle_pct = 17;
        rx_idle_pct = 17;
        apply_setting(32'd0, 32'd0, 1'b0, 32'd1);
        send_records(120);
        apply_setting(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'd16);
        send_records(120);
        apply_setting(32'h8000_0000, 32'h8000_0000, 1'b1, 32'd5);
        send_records(120);
        apply_setting($urandom(), $urandom(), 1'b0, 32'd37);
        send_records(120);
        apply_setting($urandom(), $urandom(), 1'b1, 32'd300);
        send_records(300);
        apply_setting(32'd1, 32'hFFFF_FFFF, 1'b1, 32'd0);
        send_records(120);
    endtask

    task automatic test_idle_phases();
        int tx_pct [4] = '{0, 83, 0, 17};
        int rx_pct [4] = '{0, 0, 83, 17};
        for (int p = 0; p < 4; p++) begin
            tx_idle_pct = tx_pct[p];
            rx_idle_pct = rx_pct[p];
            apply_setting($urandom(), $urandom(), 1'($urandom_range(1)),
                          $urandom_range(1, 48));
            send_records(150);
        end
    endtask

    task automatic test_output_hold_off();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        apply_setting($urandom(), $urandom(), 1'b1, 32'd24);
        hold_req = 300;
        send_records(130);
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_setting_sweep();
        test_idle_phases();
        test_output_hold_off();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
